// File: rtl/gcsr_pkg.sv
package gcsr_pkg;

   // Access command
   typedef enum logic {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } gcsr_cmd_type;

   // Completion status
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_UNKNOWN = 2'd1,
      STATUS_STRAY   = 2'd2
   } gcsr_status_type;

   // CSR numbers
   localparam logic [11:0] ADDR_SSTATUS   = 12'h100;
   localparam logic [11:0] ADDR_SIE       = 12'h104;
   localparam logic [11:0] ADDR_STVEC     = 12'h105;
   localparam logic [11:0] ADDR_SIP       = 12'h144;
   localparam logic [11:0] ADDR_SATP      = 12'h180;
   localparam logic [11:0] ADDR_MSTATUS   = 12'h300;
   localparam logic [11:0] ADDR_MEDELEG   = 12'h302;
   localparam logic [11:0] ADDR_MIDELEG   = 12'h303;
   localparam logic [11:0] ADDR_MIE       = 12'h304;
   localparam logic [11:0] ADDR_MTVEC     = 12'h305;
   localparam logic [11:0] ADDR_MSCRATCH  = 12'h340;
   localparam logic [11:0] ADDR_MEPC      = 12'h341;
   localparam logic [11:0] ADDR_MCAUSE    = 12'h342;
   localparam logic [11:0] ADDR_MTVAL     = 12'h343;
   localparam logic [11:0] ADDR_MIP       = 12'h344;
   localparam logic [11:0] ADDR_PMP_FIRST = 12'h3A0;
   localparam logic [11:0] ADDR_PMP_LAST  = 12'h3EF;
   localparam logic [11:0] ADDR_MHARTID   = 12'hF14;

   // Field widths and masks
   localparam int unsigned XLEN         = 64;
   localparam int unsigned HART_W       = 8;
   localparam int unsigned PPN_W        = 44;
   localparam int unsigned SATP_MODE_LO = 60;
   localparam logic [1:0]  XL_64        = 2'd2;
   localparam logic [63:0] ALL_ENABLES  = 64'h0000_0000_0000_0AAA;
   localparam logic [63:0] S_ENABLES    = 64'h0000_0000_0000_0222;
   localparam logic [5:0]  M_ONLY_PACKED = 6'h2A;

   typedef struct packed {
      gcsr_cmd_type command;
      logic [11:0]  csr_addr;
      logic [63:0]  write_value;
   } gcsr_req_type;

   typedef struct packed {
      logic [63:0]     read_data;
      gcsr_status_type status;
      logic            satp_written;
   } gcsr_rsp_type;

   // Spread packed enables to mie bit positions 1,3,5,7,9,11
   function automatic logic [63:0] enables_to_mie(input logic [5:0] packed_en);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 6; i++) begin
         r[2*i+1] = packed_en[i];
      end
      return r;
   endfunction

   // Gather mie bit positions 1,3,5,7,9,11 into packed enables
   function automatic logic [5:0] mie_to_enables(input logic [63:0] v);
      logic [5:0] r;
      r = '0;
      for (int i = 0; i < 6; i++) begin
         r[i] = v[2*i+1];
      end
      return r;
   endfunction

endpackage

// File: rtl/gcsr_req_stage.sv
module gcsr_req_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gcsr_pkg::gcsr_req_type req_in,
   input  logic                  take,
   output logic                  valid,
   output gcsr_pkg::gcsr_req_type req_out
);
   import gcsr_pkg::*;

   logic         valid_ff, valid_in;
   gcsr_req_type req_ff;
   logic         accept;

   // Hold the transaction until the execute side takes it
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
   end

   assign valid   = valid_ff;
   assign req_out = req_ff;

endmodule

// File: rtl/gcsr_core.sv
module gcsr_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [7:0]            csr_wdata,
   input  logic                  exec,
   input  gcsr_pkg::gcsr_req_type req,
   output gcsr_pkg::gcsr_rsp_type rsp
);
   import gcsr_pkg::*;

   logic [HART_W-1:0] hart_ff;
   logic [1:0]  mpp_ff, mpp_in;
   logic        spp_ff, spp_in;
   logic        mie_ff, mie_in;
   logic        sie_ff, sie_in;
   logic        mdt_ff, mdt_in;
   logic [5:0]  enables_ff, enables_in;
   logic [63:0] mtvec_ff, mtvec_in;
   logic [63:0] stvec_ff, stvec_in;
   logic [3:0]  satp_mode_ff, satp_mode_in;
   logic [PPN_W-1:0] ppn_ff, ppn_in;
   logic [63:0] mepc_ff, mepc_in;
   logic [63:0] mscratch_ff, mscratch_in;
   logic [63:0] mcause_ff, mcause_in;
   logic [63:0] mtval_ff, mtval_in;
   logic [63:0] medeleg_ff, medeleg_in;
   logic [63:0] mideleg_ff, mideleg_in;

   logic            is_pmp;
   logic [63:0]     v;
   logic [63:0]     rd;
   gcsr_status_type st;
   logic            pulse;

   assign is_pmp = (req.csr_addr >= ADDR_PMP_FIRST) && (req.csr_addr <= ADDR_PMP_LAST);
   assign v      = req.write_value;

   // Decode the access: read value, status and next state
   always_comb begin
      mpp_in       = mpp_ff;
      spp_in       = spp_ff;
      mie_in       = mie_ff;
      sie_in       = sie_ff;
      mdt_in       = mdt_ff;
      enables_in   = enables_ff;
      mtvec_in     = mtvec_ff;
      stvec_in     = stvec_ff;
      satp_mode_in = satp_mode_ff;
      ppn_in       = ppn_ff;
      mepc_in      = mepc_ff;
      mscratch_in  = mscratch_ff;
      mcause_in    = mcause_ff;
      mtval_in     = mtval_ff;
      medeleg_in   = medeleg_ff;
      mideleg_in   = mideleg_ff;
      rd           = '0;
      st           = STATUS_OK;
      pulse        = 1'b0;

      if (req.command == CMD_READ) begin
         if (!is_pmp) begin
            unique case (req.csr_addr)
               ADDR_MSTATUS: begin
                  rd[33:32] = XL_64;
                  rd[35:34] = XL_64;
                  rd[12:11] = mpp_ff;
                  rd[8]     = spp_ff;
                  rd[3]     = mie_ff;
                  rd[1]     = sie_ff;
                  rd[42]    = mdt_ff;
               end
               ADDR_SSTATUS: begin
                  rd[33:32] = XL_64;
                  rd[8]     = spp_ff;
                  rd[1]     = sie_ff;
               end
               ADDR_MIE:      rd = enables_to_mie(enables_ff);
               ADDR_SIE:      rd = enables_to_mie(enables_ff) & S_ENABLES;
               ADDR_MTVEC:    rd = mtvec_ff;
               ADDR_STVEC:    rd = stvec_ff;
               ADDR_SATP:     rd = {satp_mode_ff, {(SATP_MODE_LO-PPN_W){1'b0}}, ppn_ff};
               ADDR_MEPC:     rd = mepc_ff;
               ADDR_MSCRATCH: rd = mscratch_ff;
               ADDR_MCAUSE:   rd = mcause_ff;
               ADDR_MTVAL:    rd = mtval_ff;
               ADDR_MHARTID:  rd = {{(XLEN-HART_W){1'b0}}, hart_ff};
               ADDR_MEDELEG:  rd = medeleg_ff;
               ADDR_MIDELEG:  rd = mideleg_ff;
               ADDR_MIP,
               ADDR_SIP:      rd = '0;
               default:       st = STATUS_UNKNOWN;
            endcase
         end
      end else if (!is_pmp) begin
         unique case (req.csr_addr)
            ADDR_MSTATUS: begin
               mpp_in = v[12:11];
               spp_in = v[8];
               mie_in = v[3];
               sie_in = v[1];
               // MDT can be set, never cleared
               mdt_in = mdt_ff | v[42];
            end
            ADDR_SSTATUS: begin
               spp_in = v[8];
               sie_in = v[1];
            end
            ADDR_MIE: begin
               enables_in = mie_to_enables(v & ALL_ENABLES);
               if ((v & ~ALL_ENABLES) != '0) begin
                  st = STATUS_STRAY;
               end
            end
            ADDR_SIE: begin
               // Keep machine enables, replace supervisor ones
               enables_in = (enables_ff & M_ONLY_PACKED) | mie_to_enables(v & S_ENABLES);
               if ((v & ~S_ENABLES) != '0) begin
                  st = STATUS_STRAY;
               end
            end
            ADDR_MTVEC:    mtvec_in = v;
            ADDR_STVEC:    stvec_in = v;
            ADDR_SATP: begin
               ppn_in       = v[PPN_W-1:0];
               satp_mode_in = v[63:SATP_MODE_LO];
               pulse        = 1'b1;
            end
            ADDR_MEPC:     mepc_in = v;
            ADDR_MSCRATCH: mscratch_in = v;
            ADDR_MCAUSE:   mcause_in = v;
            ADDR_MTVAL:    mtval_in = v;
            ADDR_MEDELEG:  medeleg_in = v;
            ADDR_MIDELEG:  mideleg_in = v;
            ADDR_MIP,
            ADDR_SIP: begin
            end
            default:       st = STATUS_UNKNOWN;
         endcase
      end
   end

   assign rsp.read_data    = rd;
   assign rsp.status       = st;
   assign rsp.satp_written = pulse;

   // Hart number register
   always_ff @(posedge clock) begin
      if (reset) begin
         hart_ff <= '0;
      end else if (csr_we) begin
         hart_ff <= csr_wdata;
      end
   end

   // Commit state as the transaction moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mpp_ff       <= '0;
         spp_ff       <= 1'b0;
         mie_ff       <= 1'b0;
         sie_ff       <= 1'b0;
         mdt_ff       <= 1'b0;
         enables_ff   <= '0;
         mtvec_ff     <= '0;
         stvec_ff     <= '0;
         satp_mode_ff <= '0;
         ppn_ff       <= '0;
         mepc_ff      <= '0;
         mscratch_ff  <= '0;
         mcause_ff    <= '0;
         mtval_ff     <= '0;
         medeleg_ff   <= '0;
         mideleg_ff   <= '0;
      end else if (exec) begin
         mpp_ff       <= mpp_in;
         spp_ff       <= spp_in;
         mie_ff       <= mie_in;
         sie_ff       <= sie_in;
         mdt_ff       <= mdt_in;
         enables_ff   <= enables_in;
         mtvec_ff     <= mtvec_in;
         stvec_ff     <= stvec_in;
         satp_mode_ff <= satp_mode_in;
         ppn_ff       <= ppn_in;
         mepc_ff      <= mepc_in;
         mscratch_ff  <= mscratch_in;
         mcause_ff    <= mcause_in;
         mtval_ff     <= mtval_in;
         medeleg_ff   <= medeleg_in;
         mideleg_ff   <= mideleg_in;
      end
   end

endmodule

// File: rtl/gcsr_rsp_stage.sv
module gcsr_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   input  gcsr_pkg::gcsr_rsp_type rsp_in,
   output logic                  take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gcsr_pkg::gcsr_rsp_type rsp_out
);
   import gcsr_pkg::*;

   logic         valid_ff, valid_in;
   gcsr_rsp_type rsp_ff;

   // Room for a new result when empty or when the current one leaves
   assign take = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load result payload; hold while stalled
   always_ff @(posedge clock) begin
      if (take && load_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out   = rsp_ff;

endmodule

// File: rtl/riscv_guest_csr_file.sv
// Machine/supervisor CSR file for one guest hart. Each request transaction is
// one CSR read or write; it sits in an input register, is decoded and applied
// to the CSR state as its result is loaded into an output register. One
// access per cycle is sustained when the result side does not stall.
// Back-pressure from rsp_stall reaches req_stall in the same cycle. Writes
// take effect in the order of the transactions, so a read right after a write
// sees the new value. mhartid is loaded through csr_we/csr_wdata and must only
// be changed while no transaction is in flight.
module riscv_guest_csr_file (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [11:0] req_csr_addr,
   input  logic [63:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_read_data,
   output logic [1:0]  rsp_status,
   output logic        rsp_satp_written
);
   import gcsr_pkg::*;

   gcsr_req_type req_in;
   gcsr_req_type req_q;
   gcsr_rsp_type rsp_next;
   gcsr_rsp_type rsp_q;
   logic         req_q_valid;
   logic         take;
   logic         exec;

   assign req_in.command     = gcsr_cmd_type'(req_command);
   assign req_in.csr_addr    = req_csr_addr;
   assign req_in.write_value = req_write_value;

   // Execute when the input register holds a transaction and the result slot is free
   assign exec = req_q_valid && take;

   gcsr_req_stage u_req_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_in    (req_in),
      .take      (take),
      .valid     (req_q_valid),
      .req_out   (req_q)
   );

   gcsr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .exec      (exec),
      .req       (req_q),
      .rsp       (rsp_next)
   );

   gcsr_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_q_valid),
      .rsp_in     (rsp_next),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_out    (rsp_q)
   );

   assign rsp_read_data    = rsp_q.read_data;
   assign rsp_status       = rsp_q.status;
   assign rsp_satp_written = rsp_q.satp_written;

endmodule

// File: bench/riscv_guest_csr_file_tb.sv
module riscv_guest_csr_file_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gcsr_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 150;   // per idling phase
   localparam int DRAIN_CYCLES = 8;

   // Directed access row; the expected fields count only when exact is set
   typedef struct packed {
      logic        cmd;
      logic [11:0] addr;
      logic [63:0] value;
      bit          exact;
      logic [63:0] rd;
      logic [1:0]  st;
      logic        pulse;
   } access_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = 1'b0;
   logic [11:0] req_csr_addr = '0;
   logic [63:0] req_write_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_read_data;
   logic [1:0]  rsp_status;
   logic        rsp_satp_written;

   // Shadow copy of the CSR state
   logic [7:0]  hart_shadow;
   logic [1:0]  mpp_shadow;
   logic        spp_shadow, mie_shadow, sie_shadow, mdt_shadow;
   logic [5:0]  enables_shadow;
   logic [63:0] mtvec_shadow, stvec_shadow;
   logic [3:0]  satp_mode_shadow;
   logic [43:0] satp_ppn_shadow;
   logic [63:0] mepc_shadow, mscratch_shadow, mcause_shadow, mtval_shadow;
   logic [63:0] medeleg_shadow, mideleg_shadow;

   gcsr_rsp_type   pending_results[$];
   access_row_type access_table[27];
   logic [11:0]    known_addrs[16];

   int req_idle_pct = 11;
   int rsp_idle_pct = 70;
   int errors = 0;
   int checked_count = 0;
   int random_count = 0;
   int hart_writes = 0;
   int cycle_count = 0;

   riscv_guest_csr_file uut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_csr_addr     (req_csr_addr),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .rsp_satp_written (rsp_satp_written)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Spread packed enables onto mie positions 1,3,5,7,9,11
   function automatic logic [63:0] spread_enables(input logic [5:0] e);
      return {52'b0, e[5], 1'b0, e[4], 1'b0, e[3], 1'b0, e[2], 1'b0,
              e[1], 1'b0, e[0], 1'b0};
   endfunction

   function automatic logic [5:0] gather_enables(input logic [63:0] v);
      return {v[11], v[9], v[7], v[5], v[3], v[1]};
   endfunction

   // Apply one access to the shadow state and return its result
   function automatic gcsr_rsp_type apply_access(input gcsr_cmd_type cmd,
                                                 input logic [11:0] addr,
                                                 input logic [63:0] val);
      gcsr_rsp_type r;
      logic         is_pmp;
      r.read_data    = '0;
      r.status       = STATUS_OK;
      r.satp_written = 1'b0;
      is_pmp = (addr >= ADDR_PMP_FIRST) && (addr <= ADDR_PMP_LAST);
      if (cmd == CMD_READ) begin
         if (!is_pmp) begin
            case (addr)
               ADDR_MSTATUS: begin
                  r.read_data[33:32] = XL_64;
                  r.read_data[35:34] = XL_64;
                  r.read_data[12:11] = mpp_shadow;
                  r.read_data[8]     = spp_shadow;
                  r.read_data[3]     = mie_shadow;
                  r.read_data[1]     = sie_shadow;
                  r.read_data[42]    = mdt_shadow;
               end
               ADDR_SSTATUS: begin
                  r.read_data[33:32] = XL_64;
                  r.read_data[8]     = spp_shadow;
                  r.read_data[1]     = sie_shadow;
               end
               ADDR_MIE:      r.read_data = spread_enables(enables_shadow);
               ADDR_SIE:      r.read_data = spread_enables(enables_shadow) & S_ENABLES;
               ADDR_MTVEC:    r.read_data = mtvec_shadow;
               ADDR_STVEC:    r.read_data = stvec_shadow;
               ADDR_SATP:     r.read_data = {satp_mode_shadow, 16'b0, satp_ppn_shadow};
               ADDR_MEPC:     r.read_data = mepc_shadow;
               ADDR_MSCRATCH: r.read_data = mscratch_shadow;
               ADDR_MCAUSE:   r.read_data = mcause_shadow;
               ADDR_MTVAL:    r.read_data = mtval_shadow;
               ADDR_MHARTID:  r.read_data = {56'b0, hart_shadow};
               ADDR_MEDELEG:  r.read_data = medeleg_shadow;
               ADDR_MIDELEG:  r.read_data = mideleg_shadow;
               ADDR_MIP, ADDR_SIP: r.read_data = '0;
               default:       r.status = STATUS_UNKNOWN;
            endcase
         end
      end else if (!is_pmp) begin
         case (addr)
            ADDR_MSTATUS: begin
               mpp_shadow = val[12:11];
               spp_shadow = val[8];
               mie_shadow = val[3];
               sie_shadow = val[1];
               // double-trap flag can only be set by software
               if (val[42]) mdt_shadow = 1'b1;
            end
            ADDR_SSTATUS: begin
               spp_shadow = val[8];
               sie_shadow = val[1];
            end
            ADDR_MIE: begin
               enables_shadow = gather_enables(val & ALL_ENABLES);
               if ((val & ~ALL_ENABLES) != '0) r.status = STATUS_STRAY;
            end
            ADDR_SIE: begin
               enables_shadow = (enables_shadow & M_ONLY_PACKED) |
                                gather_enables(val & S_ENABLES);
               if ((val & ~S_ENABLES) != '0) r.status = STATUS_STRAY;
            end
            ADDR_MTVEC:    mtvec_shadow = val;
            ADDR_STVEC:    stvec_shadow = val;
            ADDR_SATP: begin
               satp_ppn_shadow  = val[43:0];
               satp_mode_shadow = val[63:60];
               r.satp_written   = 1'b1;
            end
            ADDR_MEPC:     mepc_shadow = val;
            ADDR_MSCRATCH: mscratch_shadow = val;
            ADDR_MCAUSE:   mcause_shadow = val;
            ADDR_MTVAL:    mtval_shadow = val;
            ADDR_MEDELEG:  medeleg_shadow = val;
            ADDR_MIDELEG:  mideleg_shadow = val;
            ADDR_MIP, ADDR_SIP: ;
            default:       r.status = STATUS_UNKNOWN;
         endcase
      end
      return r;
   endfunction

   // Present one transaction, hold it until accepted, then queue its result
   task automatic send_access(input gcsr_cmd_type cmd, input logic [11:0] addr,
                              input logic [63:0] val, input gcsr_rsp_type exp);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_csr_addr    <= addr;
      req_write_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(exp);
   endtask

   // Drain all results, then load a new hart number
   task automatic set_hart_number(input logic [7:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we      <= 1'b0;
      hart_shadow = value;
      hart_writes++;
   endtask

   function automatic logic [11:0] pick_addr();
      int r;
      r = $urandom_range(99);
      if (r < 75) return known_addrs[$urandom_range(15)];
      if (r < 85) return 12'($urandom_range(ADDR_PMP_FIRST, ADDR_PMP_LAST));
      return 12'($urandom);
   endfunction

   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      case ($urandom_range(4))
         0, 1: v = {$urandom, $urandom};
         2:    v = $urandom_range(1) ? '1 : '0;
         3:    v = 64'h1 << $urandom_range(63);
         default: v = {$urandom, $urandom} & ($urandom_range(1) ? ALL_ENABLES : S_ENABLES);
      endcase
      return v;
   endfunction

   task automatic run_random(input int count);
      gcsr_cmd_type cmd;
      logic [11:0]  addr;
      logic [63:0]  val;
      gcsr_rsp_type exp;
      for (int i = 0; i < count; i++) begin
         cmd  = $urandom_range(1) ? CMD_WRITE : CMD_READ;
         addr = pick_addr();
         val  = pick_value();
         exp  = apply_access(cmd, addr, val);
         send_access(cmd, addr, val, exp);
         random_count++;
      end
   endtask

   // Drive back-pressure on the result side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      gcsr_rsp_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with no transaction pending, got %h/%0d/%0d",
                     $time, rsp_read_data, rsp_status, rsp_satp_written);
            errors++;
         end else begin
            exp = pending_results.pop_front();
            checked_count++;
            if (rsp_read_data !== exp.read_data) begin
               $display("%0t: read_data mismatch, expected %h, got %h",
                        $time, exp.read_data, rsp_read_data);
               errors++;
            end
            if (rsp_status !== exp.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, exp.status, rsp_status);
               errors++;
            end
            if (rsp_satp_written !== exp.satp_written) begin
               $display("%0t: satp_written mismatch, expected %0d, got %0d",
                        $time, exp.satp_written, rsp_satp_written);
               errors++;
            end
         end
      end
   end

   // Stop a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAIL riscv_guest_csr_file");
      $finish;
   end

   initial begin
      gcsr_rsp_type exp;
      gcsr_rsp_type pred;

      known_addrs = '{ADDR_SSTATUS, ADDR_SIE, ADDR_STVEC, ADDR_SIP, ADDR_SATP,
                      ADDR_MSTATUS, ADDR_MEDELEG, ADDR_MIDELEG, ADDR_MIE,
                      ADDR_MTVEC, ADDR_MSCRATCH, ADDR_MEPC, ADDR_MCAUSE,
                      ADDR_MTVAL, ADDR_MIP, ADDR_MHARTID};

      access_table = '{
         // state right after reset
         '{CMD_READ,  ADDR_MSTATUS, 64'h0, 1'b1, 64'h0000_000A_0000_0000, STATUS_OK, 1'b0},
         '{CMD_READ,  ADDR_SSTATUS, 64'h0, 1'b1, 64'h0000_0002_0000_0000, STATUS_OK, 1'b0},
         '{CMD_READ,  ADDR_MHARTID, 64'h0, 1'b1, 64'h0, STATUS_OK, 1'b0},
         '{CMD_READ,  ADDR_SATP,    64'h0, 1'b1, 64'h0, STATUS_OK, 1'b0},
         // status fields and the sticky double-trap flag
         '{CMD_WRITE, ADDR_MSTATUS, '1,    1'b1, 64'h0, STATUS_OK, 1'b0},
         '{CMD_READ,  ADDR_MSTATUS, 64'h0, 1'b0, 64'h0, STATUS_OK, 1'b0},
         '{CMD_WRITE, ADDR_MSTATUS, 64'h0, 1'b1, 64'h0, STATUS_OK, 1'b0},
         '{CMD_READ,  ADDR_MSTATUS, 64'h0, 1'b0, 64'h0, STATUS_OK, 1'b0},
         '{CMD_WRITE, ADDR_SSTATUS, '1,    1'b1, 64'h0, STATUS_OK, 1'b0},
         '{CMD_READ,  ADDR_SSTATUS, 64'h0, 1'b0, 64'h0, STATUS_OK, 1'b0},
         // interrupt enables, clean and with stray bits
         '{CMD_WRITE, ADDR_MIE, 64'hAAA,   1'b1, 64'h0, STATUS_OK, 1'b0},
         '{CMD_WRITE, ADDR_MIE, '1,        1'b1, 64'h0, STATUS_STRAY, 1'b0},
         '{CMD_READ,  ADDR_MIE, 64'h0,     1'b0, 64'h0, STATUS_OK, 1'b0},
         '{CMD_WRITE, ADDR_SIE, 64'h0,     1'b1, 64'h0, STATUS_OK, 1'b0},
         '{CMD_WRITE, ADDR_SIE, 64'h888,   1'b1, 64'h0, STATUS_STRAY, 1'b0},
         '{CMD_READ,  ADDR_SIE, 64'h0,     1'b0, 64'h0, STATUS_OK, 1'b0},
         '{CMD_READ,  ADDR_MIE, 64'h0,     1'b0, 64'h0, STATUS_OK, 1'b0},
         // satp pulse on every write
         '{CMD_WRITE, ADDR_SATP, '1,       1'b1, 64'h0, STATUS_OK, 1'b1},
         '{CMD_READ,  ADDR_SATP, 64'h0,    1'b0, 64'h0, STATUS_OK, 1'b0},
         '{CMD_WRITE, ADDR_SATP, 64'h0,    1'b1, 64'h0, STATUS_OK, 1'b1},
         // unknown and read-only addresses, the PMP range and mtvec
         '{CMD_WRITE, ADDR_MHARTID, '1,    1'b1, 64'h0, STATUS_UNKNOWN, 1'b0},
         '{CMD_READ,  12'hFFF, 64'h0,      1'b1, 64'h0, STATUS_UNKNOWN, 1'b0},
         '{CMD_WRITE, 12'h000, '1,         1'b1, 64'h0, STATUS_UNKNOWN, 1'b0},
         '{CMD_WRITE, ADDR_PMP_FIRST, '1,  1'b1, 64'h0, STATUS_OK, 1'b0},
         '{CMD_READ,  ADDR_PMP_LAST, 64'h0, 1'b1, 64'h0, STATUS_OK, 1'b0},
         '{CMD_WRITE, ADDR_MTVEC, '1,      1'b1, 64'h0, STATUS_OK, 1'b0},
         '{CMD_READ,  ADDR_MTVEC, 64'h0,   1'b0, 64'h0, STATUS_OK, 1'b0}
      };

      hart_shadow      = '0;
      mpp_shadow       = '0;
      spp_shadow       = 1'b0;
      mie_shadow       = 1'b0;
      sie_shadow       = 1'b0;
      mdt_shadow       = 1'b0;
      enables_shadow   = '0;
      mtvec_shadow     = '0;
      stvec_shadow     = '0;
      satp_mode_shadow = '0;
      satp_ppn_shadow  = '0;
      mepc_shadow      = '0;
      mscratch_shadow  = '0;
      mcause_shadow    = '0;
      mtval_shadow     = '0;
      medeleg_shadow   = '0;
      mideleg_shadow   = '0;

      // hold reset
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed pass, sender idles lightly, receiver heavily
      set_hart_number(8'h00);
      foreach (access_table[i]) begin
         pred = apply_access(gcsr_cmd_type'(access_table[i].cmd), access_table[i].addr,
                             access_table[i].value);
         if (access_table[i].exact) begin
            exp.read_data    = access_table[i].rd;
            exp.status       = gcsr_status_type'(access_table[i].st);
            exp.satp_written = access_table[i].pulse;
         end else begin
            exp = pred;
         end
         send_access(gcsr_cmd_type'(access_table[i].cmd), access_table[i].addr,
                     access_table[i].value, exp);
      end

      set_hart_number(8'hFF);
      run_random(RANDOM_ITEMS);

      // swap idling between the two sides
      req_idle_pct = 70;
      rsp_idle_pct = 11;
      set_hart_number(8'($urandom_range(1, 254)));
      run_random(RANDOM_ITEMS);

      // back-to-back traffic
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_hart_number(8'h00);
      run_random(RANDOM_ITEMS);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d directed and %0d random CSR accesses over %0d hart ids,",
               $size(access_table), random_count, hart_writes);
      $display("checked %0d results with %0d mismatches", checked_count, errors);
      if (errors == 0) begin
         $display("PASS riscv_guest_csr_file");
      end else begin
         $display("FAIL riscv_guest_csr_file");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/gcsr_pkg.sv
rtl/gcsr_req_stage.sv
rtl/gcsr_core.sv
rtl/gcsr_rsp_stage.sv
rtl/riscv_guest_csr_file.sv
bench/riscv_guest_csr_file_tb.sv
